// File: src/wps_pkg.sv
package wps_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinTemp  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxTemp  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPreheat  = 2'd2;

  localparam logic [7:0] MinTempReset = 8'd5;
  localparam logic [7:0] MaxTempReset = 8'd30;
  localparam logic [5:0] PreheatReset = 6'd30;
  localparam logic [7:0] IdleTarget   = 8'd20;
  localparam logic [4:0] HoursPerDay  = 5'd24;
  localparam logic [5:0] MinsPerHour  = 6'd60;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_REWRITE = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_BAD6    = 3'd6,
    CMD_BAD7    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    PH_DISABLED = 3'd0,
    PH_ARMED    = 3'd1,
    PH_PREHEAT  = 3'd2,
    PH_READY    = 3'd3,
    PH_EXPIRED  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } fsm_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  index;
    logic        time_valid;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [2:0]  weekday;
    logic signed [11:0] temp_tenths;
    logic [4:0]  entry_hour;
    logic [5:0]  entry_minute;
    logic [7:0]  entry_target;
    logic [6:0]  entry_days;
    logic        enable;
  } in_word_t;

  typedef struct packed {
    logic       ok;
    logic       active_valid;
    logic [2:0] active_index;
    logic [2:0] active_state;
    logic       heat_request;
    logic [7:0] active_target;
    logic [3:0] entry_count;
  } out_word_t;

  // Token handed from cell to cell during a walk
  typedef struct packed {
    logic       add_pending;  // add not yet placed
    logic       best_valid;
    logic [4:0] best_hour;
    logic [5:0] best_minute;
    logic [3:0] best_slot;
    logic [2:0] best_phase;
    logic [7:0] best_target;
    logic [4:0] count;
  } token_t;

  // Per-word command info broadcast to all cells
  typedef struct packed {
    logic       start;    // first walk cycle
    logic       step;     // cell takes token this cycle
    logic       tick;     // valid tick
    logic       add;      // add with good params and room
    logic       remove;
    logic       en_cmd;
    logic       rewrite;  // rewrite with good params
    logic       clear;
  } ctl_t;

  // lexicographic (ah,am) >= (bh,bm)
  function automatic logic at_or_after(input logic [5:0] ah, input logic [5:0] am,
                                       input logic [5:0] bh, input logic [5:0] bm);
    return (ah > bh) || ((ah == bh) && (am >= bm));
  endfunction

endpackage

// File: src/wps_if.sv
interface wps_if #(
  parameter int unsigned W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/wps_cell.sv
module wps_cell #(
  parameter logic [3:0] SlotIdx = 4'd0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wps_pkg::ctl_t     ctl_i,
  input  wps_pkg::in_word_t word_i,
  input  logic [5:0]        preheat_i,
  input  wps_pkg::token_t   tok_i,
  output wps_pkg::token_t   tok_o
);
  import wps_pkg::*;

  logic       en_q, en_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] min_q, min_d;
  logic [7:0] tgt_q, tgt_d;
  logic [6:0] days_q, days_d;
  phase_e     ph_q, ph_d;

  logic signed [7:0]  dm;
  logic [4:0]  sh;
  logic [5:0]  sm;
  logic [4:0]  stop_h;
  logic        start_due, stop_due, warm, hit, match;
  logic signed [13:0] thr;
  phase_e      ph_tick;

  // preheat start time, modulo one day; lead is under 64 minutes, so at most two hour borrows
  always_comb begin
    dm = signed'({2'b00, min_q}) - signed'({2'b00, preheat_i});
    if (dm >= 8'sd0) begin
      sm = 6'(dm);
      sh = hour_q;
    end else if (dm >= -8'sd60) begin
      sm = 6'(dm + 8'sd60);
      sh = (hour_q == 5'd0) ? 5'd23 : hour_q - 5'd1;
    end else begin
      sm = 6'(dm + 8'sd120);
      sh = (hour_q < 5'd2) ? hour_q + 5'd22 : hour_q - 5'd2;
    end
  end

  always_comb begin
    start_due = (word_i.weekday <= 3'd6) && days_q[word_i.weekday[2:0]] &&
                at_or_after({1'b0, word_i.now_hour}, word_i.now_minute, {1'b0, sh}, sm) &&
                !at_or_after({1'b0, word_i.now_hour}, word_i.now_minute,
                             {1'b0, hour_q}, min_q);
    stop_h    = (hour_q >= 5'd23) ? 5'd0 : hour_q + 5'd1;
    stop_due  = at_or_after({1'b0, word_i.now_hour}, word_i.now_minute,
                            {1'b0, stop_h}, min_q);
    // ready within one degree; target 0 gives a negative threshold
    thr       = signed'(14'(tgt_q)) * 14'sd10 - 14'sd10;
    warm      = 14'(word_i.temp_tenths) >= thr;
  end

  // tick phase update
  always_comb begin
    ph_tick = ph_q;
    unique case (ph_q)
      PH_ARMED:   if (start_due) ph_tick = PH_PREHEAT;
      PH_PREHEAT: begin
        if (warm) ph_tick = PH_READY;
        else if (stop_due) ph_tick = PH_EXPIRED;
      end
      PH_READY:   if (stop_due) ph_tick = PH_EXPIRED;
      default:    ;
    endcase
  end

  // cell step: update own slot and pass the token on
  always_comb begin
    en_d   = en_q;
    hour_d = hour_q;
    min_d  = min_q;
    tgt_d  = tgt_q;
    days_d = days_q;
    ph_d   = ph_q;
    tok_o  = tok_i;
    match  = (word_i.index == SlotIdx);
    hit    = 1'b0;
    if (ctl_i.step) begin
      // a tick picks the active entry afresh
      if (ctl_i.start && ctl_i.tick) begin
        tok_o.best_valid = 1'b0;
        tok_o.best_slot  = '0;
      end
      if (ctl_i.clear) begin
        en_d = 1'b0;
        ph_d = PH_DISABLED;
      end else if (ctl_i.add && tok_i.add_pending && !en_q) begin
        en_d   = 1'b1;
        hour_d = word_i.entry_hour;
        min_d  = word_i.entry_minute;
        tgt_d  = word_i.entry_target;
        days_d = word_i.entry_days;
        ph_d   = PH_ARMED;
        tok_o.add_pending = 1'b0;
      end else if (ctl_i.remove && match) begin
        en_d = 1'b0;
        ph_d = PH_DISABLED;
      end else if (ctl_i.en_cmd && match && (en_q != word_i.enable)) begin
        en_d = word_i.enable;
        ph_d = word_i.enable ? PH_ARMED : PH_DISABLED;
      end else if (ctl_i.rewrite && match) begin
        hour_d = word_i.entry_hour;
        min_d  = word_i.entry_minute;
        tgt_d  = word_i.entry_target;
        days_d = word_i.entry_days;
      end else if (ctl_i.tick && en_q) begin
        hit = (ph_tick == PH_PREHEAT) || (ph_tick == PH_READY);
        if (hit && (!tok_o.best_valid || hour_q < tok_o.best_hour ||
                    (hour_q == tok_o.best_hour && min_q < tok_o.best_minute))) begin
          tok_o.best_valid  = 1'b1;
          tok_o.best_hour   = hour_q;
          tok_o.best_minute = min_q;
          tok_o.best_slot   = SlotIdx;
          tok_o.best_phase  = ph_tick;
          tok_o.best_target = tgt_q;
        end
        ph_d = (ph_tick == PH_EXPIRED) ? PH_ARMED : ph_tick;
      end
      // non-tick commands: refresh the active entry's view
      if (!ctl_i.tick && tok_i.best_valid && tok_i.best_slot == SlotIdx) begin
        if (!en_d) tok_o.best_valid = 1'b0;
        tok_o.best_phase  = ph_d;
        tok_o.best_target = tgt_d;
      end
      tok_o.count = tok_i.count + 5'(en_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      hour_q <= 5'd7;
      min_q  <= 6'd0;
      tgt_q  <= IdleTarget;
      days_q <= 7'h3E;
      ph_q   <= PH_DISABLED;
    end else begin
      en_q   <= en_d;
      hour_q <= hour_d;
      min_q  <= min_d;
      tgt_q  <= tgt_d;
      days_q <= days_d;
      ph_q   <= ph_d;
    end
  end
endmodule

// File: src/wakeup_preheat_scheduler_unit.sv
// Wake-up preheat scheduler. Each command word walks a row of SLOTS slot cells, one cell per
// cycle, carrying a token with the running earliest-active pick and the enabled count; the
// result word is registered in the output register after the last cell steps, and the next
// word is taken only once that result has left the output register, so the receiver's stalls
// hold off new words. Configuration writes (min_temp, max_temp, preheat_minutes) must only
// happen while idle.
module wakeup_preheat_scheduler_unit #(
  parameter int unsigned SLOTS = wps_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wps_pkg::CfgDataW-1:0]  cfg_data_i,
  wps_if.sink                           in_if,
  wps_if.source                         out_if
);
  import wps_pkg::*;

  localparam int unsigned CntW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [7:0] min_temp_q, max_temp_q;
  logic [5:0] preheat_q;

  fsm_e       st_q, st_d;
  in_word_t   word_q;
  token_t     tok_q, tok_d;
  logic [CntW-1:0] pos_q, pos_d;
  out_word_t  out_q, out_d;
  ctl_t       ctl;
  logic       params_ok, idx_ok;
  logic       ok_calc;
  logic [4:0] cnt_before;

  token_t     tok_chain [SLOTS];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_temp_q <= MinTempReset;
      max_temp_q <= MaxTempReset;
      preheat_q  <= PreheatReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinTemp: min_temp_q <= cfg_data_i;
        RegMaxTemp: max_temp_q <= cfg_data_i;
        RegPreheat: preheat_q  <= cfg_data_i[5:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    params_ok = (word_q.entry_hour < HoursPerDay) && (word_q.entry_minute < MinsPerHour) &&
                (word_q.entry_target >= min_temp_q) && (word_q.entry_target <= max_temp_q);
    idx_ok    = 32'(word_q.index) < SLOTS;
  end

  // broadcast control; the add room check uses cnt_before, held stable during the walk
  always_comb begin
    ctl.start   = (st_q == ST_WALK) && (pos_q == '0);
    ctl.step    = 1'b0;
    ctl.tick    = (word_q.cmd == CMD_TICK) && word_q.time_valid;
    ctl.add     = (word_q.cmd == CMD_ADD) && params_ok && (32'(cnt_before) < SLOTS);
    ctl.remove  = (word_q.cmd == CMD_REMOVE) && idx_ok;
    ctl.en_cmd  = (word_q.cmd == CMD_ENABLE) && idx_ok;
    ctl.rewrite = (word_q.cmd == CMD_REWRITE) && idx_ok && params_ok;
    ctl.clear   = (word_q.cmd == CMD_CLEAR);
  end

  // cell row; one cell steps per cycle, chosen by pos_q
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ctl_t   c;
    always_comb begin
      c      = ctl;
      c.step = (st_q == ST_WALK) && (32'(pos_q) == g);
    end
    wps_cell #(.SlotIdx(4'(g))) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (c),
      .word_i    (word_q),
      .preheat_i (preheat_q),
      .tok_i     (tok_q),
      .tok_o     (tok_chain[g])
    );
  end

  // walk sequencer
  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    tok_d = tok_q;
    in_if.ready  = (st_q == ST_IDLE);
    out_if.valid = (st_q == ST_OUT);
    unique case (st_q)
      ST_IDLE: if (in_if.valid) begin
        st_d  = ST_WALK;
        pos_d = '0;
        tok_d.add_pending = 1'b1;
        tok_d.count = '0;
      end
      ST_WALK: begin
        tok_d = tok_chain[pos_q];
        if (32'(pos_q) == SLOTS - 1) st_d = ST_OUT;
        else pos_d = pos_q + CntW'(1);
      end
      ST_OUT: if (out_if.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // ok needs the pre-walk count for add, the cell hit for remove
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_before <= '0;
    else if (st_q == ST_OUT && out_if.ready) cnt_before <= tok_q.count;
  end
  always_comb begin
    unique case (cmd_e'(word_q.cmd))
      CMD_TICK:    ok_calc = 1'b1;
      CMD_ADD:     ok_calc = params_ok && (32'(cnt_before) < SLOTS);
      CMD_REMOVE:  ok_calc = idx_ok && (tok_d.count != cnt_before);
      CMD_ENABLE:  ok_calc = idx_ok;
      CMD_REWRITE: ok_calc = idx_ok && params_ok;
      CMD_CLEAR:   ok_calc = 1'b1;
      default:     ok_calc = 1'b0;
    endcase
  end

  // status from the token leaving the last cell
  always_comb begin
    out_d.ok            = ok_calc;
    out_d.active_valid  = tok_d.best_valid;
    out_d.active_index  = tok_d.best_valid ? tok_d.best_slot[2:0] : 3'd0;
    out_d.active_state  = tok_d.best_valid ? tok_d.best_phase : 3'd0;
    out_d.heat_request  = tok_d.best_valid &&
                          (tok_d.best_phase == PH_PREHEAT || tok_d.best_phase == PH_READY);
    out_d.active_target = tok_d.best_valid ? tok_d.best_target : IdleTarget;
    out_d.entry_count   = tok_d.count[3:0];
  end

  assign out_if.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      pos_q <= '0;
      tok_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_if.valid) word_q <= in_if.data;
    if (st_q == ST_WALK && 32'(pos_q) == SLOTS - 1) out_q <= out_d;
  end
endmodule

// File: tb/wakeup_preheat_scheduler_unit_test.sv
`timescale 1ns / 1ps

module wakeup_preheat_scheduler_unit_test;
  import wps_pkg::*;

  localparam int unsigned NSLOTS   = 8;
  localparam int unsigned LIMIT_CY = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  wps_if #(.W($bits(in_word_t))) cmd_ch ();
  wps_if #(.W($bits(out_word_t))) res_ch ();

  wakeup_preheat_scheduler_unit #(.SLOTS(NSLOTS)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(cmd_ch.sink),
    .out_if(res_ch.source)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow of the schedule table
  logic [7:0] lo_temp, hi_temp;
  logic [5:0] lead_min;
  logic       sl_en [NSLOTS];
  logic [4:0] sl_hr [NSLOTS];
  logic [5:0] sl_mn [NSLOTS];
  logic [7:0] sl_tg [NSLOTS];
  logic [6:0] sl_dy [NSLOTS];
  phase_e     sl_ph [NSLOTS];
  logic       pick_v;
  logic [2:0] pick_s;
  logic [3:0] n_enabled;

  out_word_t expected_words[$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  function automatic logic later_eq(int ah, int am, int bh, int bm);
    return (ah > bh) || ((ah == bh) && (am >= bm));
  endfunction

  function automatic logic fields_ok(logic [4:0] h, logic [5:0] m, logic [7:0] t);
    return (h < 24) && (m < 60) && (t >= lo_temp) && (t <= hi_temp);
  endfunction

  task automatic table_reset();
    lo_temp = MinTempReset;
    hi_temp = MaxTempReset;
    lead_min = PreheatReset;
    for (int i = 0; i < NSLOTS; i++) begin
      sl_en[i] = 1'b0; sl_hr[i] = 5'd7; sl_mn[i] = 6'd0; sl_tg[i] = IdleTarget;
      sl_dy[i] = 7'h3E;
      sl_ph[i] = PH_DISABLED;
    end
    pick_v = 1'b0; pick_s = 3'd0; n_enabled = 4'd0;
  endtask

  function automatic void advance_clock(int nh, int nm, int wd, int temp);
    int tot, best;
    best = -1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (!sl_en[i]) continue;
      case (sl_ph[i])
        PH_ARMED: begin
          tot = (sl_hr[i] * 60 + sl_mn[i] + 1440 - lead_min) % 1440;
          if (wd <= 6 && sl_dy[i][wd] && later_eq(nh, nm, tot / 60, tot % 60) &&
              !later_eq(nh, nm, sl_hr[i], sl_mn[i]))
            sl_ph[i] = PH_PREHEAT;
        end
        PH_PREHEAT: begin
          if (temp >= int'(sl_tg[i]) * 10 - 10) sl_ph[i] = PH_READY;
          else if (later_eq(nh, nm, (sl_hr[i] + 1 >= 24) ? 0 : sl_hr[i] + 1, sl_mn[i]))
            sl_ph[i] = PH_EXPIRED;
        end
        PH_READY: begin
          if (later_eq(nh, nm, (sl_hr[i] + 1 >= 24) ? 0 : sl_hr[i] + 1, sl_mn[i]))
            sl_ph[i] = PH_EXPIRED;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < NSLOTS; i++)
      if (sl_en[i] && (sl_ph[i] == PH_PREHEAT || sl_ph[i] == PH_READY))
        if (best < 0 || sl_hr[i] < sl_hr[best] ||
            (sl_hr[i] == sl_hr[best] && sl_mn[i] < sl_mn[best]))
          best = i;
    pick_v = (best >= 0);
    pick_s = (best >= 0) ? best[2:0] : 3'd0;
    for (int i = 0; i < NSLOTS; i++)
      if (sl_en[i] && sl_ph[i] == PH_EXPIRED) sl_ph[i] = PH_ARMED;
  endfunction

  // Apply one command word to the shadow table and return the status word
  function automatic out_word_t schedule_step(in_word_t w);
    out_word_t r;
    logic ok;
    ok = 0;
    case (cmd_e'(w.cmd))
      CMD_TICK: begin
        ok = 1;
        if (w.time_valid)
          advance_clock(w.now_hour, w.now_minute, w.weekday, int'(w.temp_tenths));
      end
      CMD_ADD: begin
        if (n_enabled < NSLOTS && fields_ok(w.entry_hour, w.entry_minute, w.entry_target))
          for (int i = 0; i < NSLOTS; i++)
            if (!ok && !sl_en[i]) begin
              sl_en[i] = 1; sl_hr[i] = w.entry_hour; sl_mn[i] = w.entry_minute;
              sl_tg[i] = w.entry_target; sl_dy[i] = w.entry_days; sl_ph[i] = PH_ARMED;
              n_enabled++;
              ok = 1;
            end
      end
      CMD_REMOVE: begin
        if (w.index < NSLOTS && sl_en[w.index]) begin
          sl_en[w.index] = 0; sl_ph[w.index] = PH_DISABLED;
          if (pick_v && pick_s == w.index) begin pick_v = 0; pick_s = 0; end
          n_enabled--;
          ok = 1;
        end
      end
      CMD_ENABLE: begin
        if (w.index < NSLOTS) begin
          ok = 1;
          if (sl_en[w.index] != w.enable) begin
            sl_en[w.index] = w.enable;
            sl_ph[w.index] = w.enable ? PH_ARMED : PH_DISABLED;
            if (w.enable) n_enabled++;
            else begin
              if (pick_v && pick_s == w.index) begin pick_v = 0; pick_s = 0; end
              n_enabled--;
            end
          end
        end
      end
      CMD_REWRITE: begin
        if (w.index < NSLOTS && fields_ok(w.entry_hour, w.entry_minute, w.entry_target)) begin
          sl_hr[w.index] = w.entry_hour; sl_mn[w.index] = w.entry_minute;
          sl_tg[w.index] = w.entry_target; sl_dy[w.index] = w.entry_days;
          ok = 1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NSLOTS; i++) begin sl_en[i] = 0; sl_ph[i] = PH_DISABLED; end
        n_enabled = 0; pick_v = 0; pick_s = 0;
        ok = 1;
      end
      default: ;
    endcase
    r.ok = ok;
    r.active_valid = pick_v;
    r.active_index = pick_v ? pick_s : 3'd0;
    r.active_state = pick_v ? sl_ph[pick_s] : 3'd0;
    r.heat_request = pick_v && (sl_ph[pick_s] == PH_PREHEAT || sl_ph[pick_s] == PH_READY);
    r.active_target = pick_v ? sl_tg[pick_s] : IdleTarget;
    r.entry_count = n_enabled;
    return r;
  endfunction

  // Drive one word and wait for its acceptance; valid drops only while idling
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    expected_words.push_back(schedule_step(w));
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegMinTemp: lo_temp = val;
      RegMaxTemp: hi_temp = val;
      default: lead_min = val[5:0];
    endcase
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    w = bits[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t make_tick(int h, int m, int wd, int temp);
    in_word_t w;
    w = rand_word();
    w.cmd = CMD_TICK; w.time_valid = 1; w.now_hour = 5'(h); w.now_minute = 6'(m);
    w.weekday = 3'(wd); w.temp_tenths = 12'(temp);
    return w;
  endfunction

  function automatic in_word_t make_entry(cmd_e c, int idx, int h, int m, int t, int d);
    in_word_t w;
    w = rand_word();
    w.cmd = c; w.index = 4'(idx); w.entry_hour = 5'(h); w.entry_minute = 6'(m);
    w.entry_target = 8'(t); w.entry_days = 7'(d);
    return w;
  endfunction

  // Plausible word: mostly adds and ticks near the table's times
  function automatic in_word_t plausible_word();
    in_word_t w;
    int k, s;
    w = rand_word();
    k = $urandom_range(99);
    s = $urandom_range(NSLOTS - 1);
    if (k < 20) begin
      w = make_entry(CMD_ADD, 0, $urandom_range(23), $urandom_range(59),
                     $urandom_range(lo_temp, hi_temp), $urandom_range(127));
    end else if (k < 70) begin
      s = sl_hr[s] * 60 + sl_mn[s] + 60 - $urandom_range(lead_min + 70);
      s = (s + 1440) % 1440;
      w = make_tick(s / 60, s % 60, $urandom_range(6), $urandom_range(0, 400) - 50);
      if ($urandom_range(9) == 0) w.temp_tenths = 12'($urandom_range(2000));
      if ($urandom_range(19) == 0) w.weekday = 3'd7;
    end else if (k < 76) begin
      w.cmd = CMD_REMOVE; w.index = 4'(s);
    end else if (k < 84) begin
      w.cmd = CMD_ENABLE; w.index = 4'(s);
    end else if (k < 90) begin
      w = make_entry(CMD_REWRITE, s, $urandom_range(23), $urandom_range(59),
                     $urandom_range(lo_temp, hi_temp), $urandom_range(127));
    end else if (k < 92) begin
      w.cmd = CMD_CLEAR;
    end
    return w;
  endfunction

  task automatic test_directed();
    send_word(make_entry(CMD_ADD, 0, 0, 0, 5, 7'h7F));
    send_word(make_entry(CMD_ADD, 0, 23, 59, 30, 7'h01));
    send_word(make_entry(CMD_ADD, 0, 24, 0, 20, 7'h7F));
    send_word(make_entry(CMD_ADD, 0, 7, 60, 20, 7'h7F));
    send_word(make_entry(CMD_ADD, 0, 7, 0, 4, 7'h7F));
    send_word(make_entry(CMD_ADD, 0, 7, 0, 31, 7'h7F));
    send_word(make_entry(CMD_ADD, 0, 31, 63, 255, 7'h00));
    send_word(make_entry(CMD_ADD, 0, 7, 0, 20, 7'h7F));
    send_word(make_tick(6, 45, 2, -1000));
    send_word(make_tick(6, 50, 7, 2000));
    send_word(make_tick(6, 50, 2, 190));
    begin
      in_word_t w;
      w = make_tick(6, 55, 2, 0); w.time_valid = 0; send_word(w);
      w.cmd = CMD_BAD6; send_word(w);
      w.cmd = CMD_BAD7; send_word(w);
      w = make_entry(CMD_REWRITE, 15, 7, 0, 20, 1); send_word(w);
      w.cmd = CMD_REMOVE; w.index = 4'd8; send_word(w);
      w.cmd = CMD_ENABLE; w.index = 4'd2; w.enable = 0; send_word(w);
      w.cmd = CMD_ENABLE; w.index = 4'd3; w.enable = 0; send_word(w);
      w.cmd = CMD_REMOVE; w.index = 4'd3; send_word(w);
      w.cmd = CMD_ENABLE; w.index = 4'd3; w.enable = 1; send_word(w);
    end
    send_word(make_tick(31, 63, 6, 100));
    send_word(make_tick(8, 0, 2, 100));
    send_word(make_entry(CMD_CLEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOTS + 1; i++)
      send_word(make_entry(CMD_ADD, 0, i, 30, 20, 7'h7F));
    send_word(make_entry(CMD_CLEAR, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n, int sidle, int rstall);
    in_word_t w;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) w = plausible_word();
      else w = rand_word();
      send_word(w);
    end
  endtask

  task automatic test_config(logic [7:0] lo, logic [7:0] hi, logic [5:0] lead);
    drain();
    write_reg(RegMinTemp, lo);
    write_reg(RegMaxTemp, hi);
    write_reg(RegPreheat, {2'b00, lead});
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stall, compare each word with the oldest expectation
  initial begin
    out_word_t got, want;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_words.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected status word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch: exp ok%b av%b ai%0d st%0d hr%b tg%0d n%0d",
                want.ok, want.active_valid, want.active_index, want.active_state,
                want.heat_request, want.active_target, want.entry_count);
              $display("          got ok%b av%b ai%0d st%0d hr%b tg%0d n%0d",
                got.ok, got.active_valid, got.active_index, got.active_state,
                got.heat_request, got.active_target, got.entry_count);
            end
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CY) begin
        $display("wakeup_preheat_scheduler_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    table_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(150, 0, 0);
    test_config(8'd0, 8'd255, 6'd1);
    test_random(150, 82, 0);
    test_config(8'd255, 8'd0, 6'd59);
    test_random(40, 0, 82);
    test_config(8'd10, 8'd25, 6'd15);
    test_random(130, 0, 82);
    test_config(8'd5, 8'd30, 6'd45);
    test_random(150, 29, 29);
    drain();
    if (n_errors == 0) begin
      $display("wakeup_preheat_scheduler_unit_test OK");
    end else begin
      $display("wakeup_preheat_scheduler_unit_test NOT OK");
    end
    $finish;
  end

endmodule
